FILE: src/ghgc_pkg.sv
// ----------------------------------------------------------------------------
// ghgc_pkg
// Shared types and constants for the grid height ground classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ghgc_pkg;

  // height store geometry, addresses wrap at the store size
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 65536;

  // 1.0 in Q0.16, one bit wider than the fraction
  localparam logic [16:0] FRAC_ONE = 17'h10000;

  // operation codes of an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X         = 3'd0,
    CFG_ORIGIN_Z         = 3'd1,
    CFG_CELL_WIDTH       = 3'd2,
    CFG_CELL_DEPTH       = 3'd3,
    CFG_GRID_WIDTH       = 3'd4,
    CFG_GROUND_THRESHOLD = 3'd5
  } cfg_idx_t;

  // input beat
  typedef struct packed {
    logic                       op;
    logic [STORE_AW-1:0]        cell_address;
    logic signed [31:0]         cell_height;
    logic signed [31:0]         point_x;
    logic signed [31:0]         point_y;
    logic signed [31:0]         point_z;
  } in_t;

  // result beat
  typedef struct packed {
    logic [31:0] point_number;
    logic        is_ground;
  } out_t;

  // per-item sideband that travels down the pipeline
  typedef struct packed {
    logic                valid;
    logic                op;
    logic [31:0]         tag;
    logic [STORE_AW-1:0] addr;
    logic [31:0]         height;
    logic [31:0]         py;
  } side_t;

endpackage

`default_nettype wire

FILE: src/ghgc_ram.sv
// ----------------------------------------------------------------------------
// ghgc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ghgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: src/ghgc_div.sv
// ----------------------------------------------------------------------------
// ghgc_div
// Pipelined restoring divider, one quotient bit per stage. Gives
// floor(dividend * 2^16 / divisor) when that value fits QB+16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ghgc_div #(
  parameter int QB = 8
) (
  input  wire logic               clk,
  input  wire logic [31:0]        dividend,
  input  wire logic [30:0]        divisor,
  output logic      [QB+15:0]     quotient
);

  localparam int K = QB + 16;

  logic [31:0]  rem_r [K];
  logic [K-1:0] quo_r [K];
  logic [K-1:0] low_r [K];

  for (genvar i = 0; i < K; i++) begin : g_stage
    logic [31:0]  rem_p;
    logic [K-1:0] quo_p;
    logic [K-1:0] low_p;
    logic [32:0]  trial;
    logic [32:0]  diff;
    logic         fits;

    // previous stage, or the leading dividend bits for the first one
    if (i == 0) begin : g_first
      assign rem_p = dividend >> QB;
      assign quo_p = '0;
      assign low_p = {dividend[QB-1:0], 16'd0};
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign quo_p = quo_r[i-1];
      assign low_p = low_r[i-1];
    end

    // shift in the next bit and try the subtract
    always_comb begin
      trial = {rem_p, low_p[K-1]};
      diff  = trial - {2'b00, divisor};
      fits  = (trial >= {2'b00, divisor});
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= fits ? diff[31:0] : trial[31:0];
      quo_r[i] <= {quo_p[K-2:0], fits};
      low_r[i] <= {low_p[K-2:0], 1'b0};
    end
  end

  assign quotient = quo_r[K-1];

endmodule

`default_nettype wire

FILE: src/ghgc_interp.sv
// ----------------------------------------------------------------------------
// ghgc_interp
// Bilinear blend of four corner heights, then the ground test against the
// point height. Seven register stages, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ghgc_interp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ghgc_pkg::side_t side_i,
  input  wire logic [31:0]     h00,
  input  wire logic [31:0]     h01,
  input  wire logic [31:0]     h10,
  input  wire logic [31:0]     h11,
  input  wire logic [16:0]     fx,
  input  wire logic [16:0]     fz,
  input  wire logic [30:0]     threshold,
  output logic                 out_valid,
  output ghgc_pkg::out_t       out_data
);

  import ghgc_pkg::*;

  side_t s1_r, s2_r, s3_r, s4_r, s5_r, s6_r;

  logic signed [49:0] m00_r, m01_r, m10_r, m11_r;
  logic [16:0]        fz1_r, fz2_r;
  logic signed [49:0] t0_r, t1_r;
  logic signed [43:0] ph0_r, ph1_r;
  logic signed [42:0] pl0_r, pl1_r;
  logic signed [44:0] sh_r;
  logic [43:0]        sl_r;
  logic signed [68:0] tot;
  logic signed [31:0] hgt_r;
  logic signed [32:0] diff_r;
  logic [32:0]        mag;
  logic               valid_r;
  out_t               data_r;

  logic [16:0] gx, gz;

  assign gx  = FRAC_ONE - fx;
  assign gz  = FRAC_ONE - fz2_r;
  assign tot = $signed({sh_r, 24'd0}) + $signed({25'd0, sl_r});
  assign mag = diff_r[32] ? (33'd0 - diff_r) : diff_r;

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
      s5_r.valid <= 1'b0;
      s6_r.valid <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      s1_r    <= side_i;
      s2_r    <= s1_r;
      s3_r    <= s2_r;
      s4_r    <= s3_r;
      s5_r    <= s4_r;
      s6_r    <= s5_r;
      valid_r <= s6_r.valid && (s6_r.op == OP_POINT);
    end
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    // weight along x
    m00_r <= $signed(h00) * $signed({1'b0, gx});
    m01_r <= $signed(h01) * $signed({1'b0, fx});
    m10_r <= $signed(h10) * $signed({1'b0, gx});
    m11_r <= $signed(h11) * $signed({1'b0, fx});
    fz1_r <= fz;
    // blend along x
    t0_r  <= m00_r + m01_r;
    t1_r  <= m10_r + m11_r;
    fz2_r <= fz1_r;
    // weight along z, each term in two partial products
    ph0_r <= $signed(t0_r[49:24]) * $signed({1'b0, gz});
    pl0_r <= $signed({1'b0, t0_r[23:0]}) * $signed({1'b0, gz});
    ph1_r <= $signed(t1_r[49:24]) * $signed({1'b0, fz2_r});
    pl1_r <= $signed({1'b0, t1_r[23:0]}) * $signed({1'b0, fz2_r});
    // sum the partial products
    sh_r  <= 45'(ph0_r) + 45'(ph1_r);
    sl_r  <= 44'(pl0_r[41:0]) + 44'(pl1_r[41:0]);
    // floor to Q16.16
    hgt_r <= tot[63:32];
    // difference to the point height
    diff_r <= 33'(hgt_r) - 33'($signed(s5_r.py));
    // ground test
    data_r.point_number <= s6_r.tag;
    data_r.is_ground    <= (mag < {2'b00, threshold});
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: src/grid_height_ground_classifier.sv
// ----------------------------------------------------------------------------
// grid_height_ground_classifier
// Stores a grid of surface heights and classifies points against the
// bilinear surface height under them.
//
//   channel  ports                                   handshake
//   input    start, busy, in_data                    start && !busy
//   result   out_valid, out_data                     strobe, one cycle
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  valid && ready
//
// One item is taken every cycle; busy and cfg_ready never drop.
// A point result is strobed once its beat has passed the input, offset, divider,
// cell, base, read and blend stages; each divider makes one quotient bit per stage
// over K = 16 + max(clog2(GRID_COLS), clog2(GRID_ROWS)) bits, 24 at the defaults.
// A grid write lands in the height store when it reaches the read stage,
// so every item sees exactly the writes taken before it.
// Reset clears the valid bits, the point counter and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_height_ground_classifier #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire ghgc_pkg::in_t                    in_data,
  output logic                                  out_valid,
  output ghgc_pkg::out_t                        out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ghgc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  import ghgc_pkg::*;

  localparam int CW   = $clog2(GRID_COLS);
  localparam int RW   = $clog2(GRID_ROWS);
  localparam int QB   = (CW > RW) ? CW : RW;
  localparam int K    = QB + 16;
  localparam int GW_W = $clog2(GRID_COLS + 1);
  localparam int MW   = QB + 31;
  localparam logic [QB-1:0] ROWS_M1 = QB'(GRID_ROWS - 1);
  localparam logic [RW-1:0] ROWS_M2 = RW'(GRID_ROWS - 2);

  typedef struct packed {
    side_t side;
    logic  negx;
    logic  hix;
    logic  negz;
    logic  hiz;
  } dly_t;

  // configuration registers
  logic signed [31:0] ox_r, oz_r;
  logic [30:0]        cw_r, cd_r, thr_r;
  logic [8:0]         gw_r;

  logic               accept;
  logic [31:0]        cnt_r, cnt_nxt;
  side_t              s0_r, s0_nxt, s1_r;
  logic signed [31:0] px0_r, pz0_r;
  logic signed [32:0] dx1_r, dz1_r;
  logic [MW-1:0]      mx1_r, mz1_r;
  logic [GW_W-1:0]    gw_eff;
  logic [30:0]        cw_eff, cd_eff;
  dly_t               dl_in;
  dly_t               dl_r [K];
  logic [K-1:0]       qx, qz;
  side_t              sa_r, sb_r, sc_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [16:0]        fxa_r, fza_r, fxb_r, fzb_r, fxc_r, fzc_r;
  logic [STORE_AW-1:0] base_r, a01, a10, a11;
  logic [31:0]        h00, h01, h10, h11;
  logic               wr_en;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r  <= '0;
      oz_r  <= '0;
      cw_r  <= 31'd65536;
      cd_r  <= 31'd65536;
      gw_r  <= 9'd256;
      thr_r <= 31'd32768;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X:         ox_r  <= cfg_data;
        CFG_ORIGIN_Z:         oz_r  <= cfg_data;
        CFG_CELL_WIDTH:       cw_r  <= cfg_data[30:0];
        CFG_CELL_DEPTH:       cd_r  <= cfg_data[30:0];
        CFG_GRID_WIDTH:       gw_r  <= cfg_data[8:0];
        CFG_GROUND_THRESHOLD: thr_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // effective grid width and cell sizes
  always_comb begin
    if (gw_r < 9'd2) begin
      gw_eff = GW_W'(2);
    end else if (32'(gw_r) > 32'(GRID_COLS)) begin
      gw_eff = GW_W'(GRID_COLS);
    end else begin
      gw_eff = GW_W'(gw_r);
    end
    cw_eff = (cw_r == '0) ? 31'd1 : cw_r;
    cd_eff = (cd_r == '0) ? 31'd1 : cd_r;
  end

  // input beat and point counter
  always_comb begin
    s0_nxt.valid  = accept;
    s0_nxt.op     = in_data.op;
    s0_nxt.tag    = cnt_r;
    s0_nxt.addr   = in_data.cell_address;
    s0_nxt.height = in_data.cell_height;
    s0_nxt.py     = in_data.point_y;
    cnt_nxt       = cnt_r;
    if (accept) begin
      cnt_nxt = (in_data.op == OP_WRITE) ? 32'd0 : cnt_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
      cnt_r      <= '0;
    end else begin
      s0_r  <= s0_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px0_r <= in_data.point_x;
    pz0_r <= in_data.point_z;
  end

  // offsets from the origin and the span limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r <= s0_r;
    end
  end

  always_ff @(posedge clk) begin
    dx1_r <= 33'(px0_r) - 33'(ox_r);
    dz1_r <= 33'(pz0_r) - 33'(oz_r);
    mx1_r <= QB'(gw_eff - GW_W'(1)) * cw_eff;
    mz1_r <= ROWS_M1 * cd_eff;
  end

  // clamp flags enter the delay line beside the dividers
  always_comb begin
    dl_in.side = s1_r;
    dl_in.negx = dx1_r[32];
    dl_in.hix  = !dx1_r[32] && (MW'(dx1_r[31:0]) >= mx1_r);
    dl_in.negz = dz1_r[32];
    dl_in.hiz  = !dz1_r[32] && (MW'(dz1_r[31:0]) >= mz1_r);
  end

  ghgc_div #(.QB(QB)) u_div_x (
    .clk      (clk),
    .dividend (dx1_r[31:0]),
    .divisor  (cw_eff),
    .quotient (qx)
  );

  ghgc_div #(.QB(QB)) u_div_z (
    .clk      (clk),
    .dividend (dz1_r[31:0]),
    .divisor  (cd_eff),
    .quotient (qz)
  );

  // sideband delay matching the divider depth
  for (genvar i = 0; i < K; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_r[i].side.valid <= 1'b0;
      end else begin
        dl_r[i] <= (i == 0) ? dl_in : dl_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // cell and fraction with edge clamping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.valid <= 1'b0;
    end else begin
      sa_r <= dl_r[K-1].side;
    end
  end

  always_ff @(posedge clk) begin
    if (dl_r[K-1].negx) begin
      col_r <= '0;
      fxa_r <= '0;
    end else if (dl_r[K-1].hix) begin
      col_r <= CW'(gw_eff - GW_W'(2));
      fxa_r <= FRAC_ONE;
    end else begin
      col_r <= CW'(qx[K-1:16]);
      fxa_r <= {1'b0, qx[15:0]};
    end
    if (dl_r[K-1].negz) begin
      row_r <= '0;
      fza_r <= '0;
    end else if (dl_r[K-1].hiz) begin
      row_r <= ROWS_M2;
      fza_r <= FRAC_ONE;
    end else begin
      row_r <= RW'(qz[K-1:16]);
      fza_r <= {1'b0, qz[15:0]};
    end
  end

  // base address of the cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else begin
      sb_r <= sa_r;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= STORE_AW'((RW + GW_W)'(row_r) * (RW + GW_W)'(gw_eff) + (RW + GW_W)'(col_r));
    fxb_r  <= fxa_r;
    fzb_r  <= fza_r;
  end

  // corner reads, grid writes in order with them
  always_comb begin
    a01   = base_r + STORE_AW'(1);
    a10   = base_r + STORE_AW'(gw_eff);
    a11   = a10 + STORE_AW'(1);
    wr_en = sb_r.valid && (sb_r.op == OP_WRITE);
  end

  ghgc_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram_top (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (sb_r.addr),
    .wdata   (sb_r.height),
    .raddr_a (base_r),
    .raddr_b (a01),
    .rdata_a (h00),
    .rdata_b (h01)
  );

  ghgc_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram_bot (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (sb_r.addr),
    .wdata   (sb_r.height),
    .raddr_a (a10),
    .raddr_b (a11),
    .rdata_a (h10),
    .rdata_b (h11)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r.valid <= 1'b0;
    end else begin
      sc_r <= sb_r;
    end
  end

  always_ff @(posedge clk) begin
    fxc_r <= fxb_r;
    fzc_r <= fzb_r;
  end

  // blend and ground test
  ghgc_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .side_i    (sc_r),
    .h00       (h00),
    .h01       (h01),
    .h10       (h10),
    .h11       (h11),
    .fx        (fxc_r),
    .fz        (fzc_r),
    .threshold (thr_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a grid write restarts the point count
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_WRITE) |=> (cnt_r == 32'd0))
    else $error("point counter not cleared by grid write");

  // each point beat advances the count by one
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.op == OP_POINT) |=> (cnt_r == $past(cnt_r) + 32'd1))
    else $error("point counter did not advance");

  // unclamped column stays inside the grid
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dl_r[K-1].side.valid && dl_r[K-1].side.op == OP_POINT &&
     !dl_r[K-1].negx && !dl_r[K-1].hix)
    |-> (32'(qx[K-1:16]) < 32'(gw_eff) - 32'd1))
    else $error("column quotient past the grid");

  // unclamped row stays inside the grid
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dl_r[K-1].side.valid && dl_r[K-1].side.op == OP_POINT &&
     !dl_r[K-1].negz && !dl_r[K-1].hiz)
    |-> (32'(qz[K-1:16]) < 32'(GRID_ROWS) - 32'd1))
    else $error("row quotient past the grid");

  // fractions never exceed one
  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    sa_r.valid |-> (fxa_r <= FRAC_ONE && fza_r <= FRAC_ONE))
    else $error("cell fraction above one");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid height ground classifier. A directed
// table covers reset values, the grid extremes and the clamping cases. Then
// random phases reprogram the registers, load the grid cells the points need
// and stream mostly well-formed points plus noise. Every result is checked
// against the table entry or a bilinear height predictor kept inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import ghgc_pkg::*;

  localparam int  COLS_MAX    = 256;
  localparam int  ROWS_MAX    = 256;
  localparam int  FLUSH_WAIT  = 64;
  localparam int  PHASES      = 11;
  localparam int  PHASE_ITEMS = 93;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  grid_height_ground_classifier dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // bench copy of the block state
  logic signed [31:0] org_x, org_z;
  logic [30:0] step_x, step_z, thr;
  logic [8:0]  cols_cfg;
  logic [31:0] heights [STORE_DEPTH];
  bit          loaded [STORE_DEPTH];
  logic [31:0] point_count;

  out_t   pending_results[$];
  int     errors = 0;
  longint cycles = 0;
  int     burst_left = 0;
  int     items_sent = 0;

  typedef struct {
    in_t  beat;
    bit   typed;
    out_t want;
  } stim_row_t;

  stim_row_t directed[$];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat point_number=%0d", out_data.point_number));
      end else begin
        want = pending_results.pop_front();
        if (out_data.point_number !== want.point_number)
          report($sformatf("point_number got %0d want %0d",
                           out_data.point_number, want.point_number));
        if (out_data.is_ground !== want.is_ground)
          report($sformatf("is_ground got %b want %b (point %0d)",
                           out_data.is_ground, want.is_ground, want.point_number));
      end
    end
  end

  function automatic longint eff_cols();
    longint g;
    g = cols_cfg;
    if (g < 2) g = 2;
    if (g > COLS_MAX) g = COLS_MAX;
    return g;
  endfunction

  // cell index clamped to 0..lim-2 and q0.16 fraction along one axis
  function automatic void locate_axis(input longint delta, input longint step,
                                      input longint lim, output longint idx,
                                      output longint frac);
    longint s;
    s = (step == 0) ? 1 : step;
    if (delta < 0) begin
      idx = 0;
      frac = 0;
    end else if (delta / s >= lim - 1) begin
      idx = lim - 2;
      frac = 65536;
    end else begin
      idx = delta / s;
      frac = ((delta % s) << 16) / s;
    end
  endfunction

  // four corner addresses (00, 01, 10, 11) and fractions under a point
  function automatic void cell_corners(input logic signed [31:0] px,
                                       input logic signed [31:0] pz,
                                       output logic [3:0][15:0] addr,
                                       output longint fx, output longint fz);
    longint gw, col, row;
    gw = eff_cols();
    locate_axis(longint'(px) - longint'(org_x), step_x, gw, col, fx);
    locate_axis(longint'(pz) - longint'(org_z), step_z, ROWS_MAX, row, fz);
    addr[0] = 16'(row * gw + col);
    addr[1] = 16'(row * gw + col + 1);
    addr[2] = 16'((row + 1) * gw + col);
    addr[3] = 16'((row + 1) * gw + col + 1);
  endfunction

  // interpolated surface height, floored to q16.16
  function automatic longint surface_height(input logic signed [31:0] px,
                                            input logic signed [31:0] pz);
    logic [3:0][15:0] a;
    longint fx, fz, acc;
    cell_corners(px, pz, a, fx, fz);
    acc = longint'($signed(heights[a[0]])) * ((65536 - fx) * (65536 - fz))
        + longint'($signed(heights[a[1]])) * (fx * (65536 - fz))
        + longint'($signed(heights[a[2]])) * ((65536 - fx) * fz)
        + longint'($signed(heights[a[3]])) * (fx * fz);
    return acc >>> 32;
  endfunction

  function automatic out_t classify_point(input in_t b);
    out_t r;
    longint diff;
    diff = surface_height(b.point_x, b.point_z) - longint'(b.point_y);
    if (diff < 0) diff = -diff;
    r.point_number = point_count;
    r.is_ground = (diff < longint'(thr));
    return r;
  endfunction

  // one input beat, paced in bursts; state updated at acceptance
  task automatic send_beat(input in_t b, input bit typed, input out_t want);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 9);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (busy);
    burst_left--;
    items_sent++;
    if (b.op == OP_WRITE) begin
      heights[b.cell_address] = b.cell_height;
      loaded[b.cell_address] = 1'b1;
      point_count = '0;
    end else begin
      pending_results.insert(pending_results.size(), typed ? want : classify_point(b));
      point_count++;
    end
  endtask

  function automatic in_t write_beat(input logic [15:0] a, input logic [31:0] h);
    in_t b;
    b.op = OP_WRITE;
    b.cell_address = a;
    b.cell_height = h;
    b.point_x = $urandom;
    b.point_y = $urandom;
    b.point_z = $urandom;
    return b;
  endfunction

  function automatic in_t point_beat(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    in_t b;
    b.op = OP_POINT;
    b.cell_address = 16'($urandom);
    b.cell_height = $urandom;
    b.point_x = x;
    b.point_y = y;
    b.point_z = z;
    return b;
  endfunction

  function automatic logic [31:0] rand_height();
    if ($urandom_range(0, 1)) return $urandom;
    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  // point beat whose corners are loaded first, so no undefined entry is read
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
    logic [3:0][15:0] a;
    longint fx, fz;
    out_t none;
    none = '0;
    cell_corners(x, z, a, fx, fz);
    for (int i = 0; i < 4; i++)
      if (!loaded[a[i]]) send_beat(write_beat(a[i], rand_height()), 1'b0, none);
    send_beat(point_beat(x, y, z), 1'b0, none);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ORIGIN_X:         org_x = v;
      CFG_ORIGIN_Z:         org_z = v;
      CFG_CELL_WIDTH:       step_x = v[30:0];
      CFG_CELL_DEPTH:       step_z = v[30:0];
      CFG_GRID_WIDTH:       cols_cfg = v[8:0];
      CFG_GROUND_THRESHOLD: thr = v[30:0];
      default: ;
    endcase
  endtask

  // all results in, then let trailing writes drain
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] pick(input logic [31:0] ext_a, input logic [31:0] ext_b,
                                       input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 7))
      0: return ext_a;
      1: return ext_b;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic stim_row_t row(input in_t b, input bit typed,
                                    input logic [31:0] n, input logic g);
    stim_row_t r;
    r.beat = b;
    r.typed = typed;
    r.want.point_number = n;
    r.want.is_ground = g;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    logic [31:0] x, y, z;
    longint gw, c, rw, cw, cd, ox, oz, hh, tt;
    int phase_end;
    in_t b;

    org_x = 0; org_z = 0;
    step_x = 31'd65536; step_z = 31'd65536;
    cols_cfg = 9'd256; thr = 31'd32768;
    point_count = '0;

    // reset state, all corners at 1.0 around the origin
    add_row(row(write_beat(16'h0000, 32'h0001_0000), 0, 0, 0));
    add_row(row(write_beat(16'h0001, 32'h0001_0000), 0, 0, 0));
    add_row(row(write_beat(16'h0100, 32'h0001_0000), 0, 0, 0));
    add_row(row(write_beat(16'h0101, 32'h0001_0000), 0, 0, 0));
    add_row(row(point_beat(32'h0, 32'h0001_0000, 32'h0), 1, 0, 1));
    // difference equal to the threshold is off-ground
    add_row(row(point_beat(32'h0, 32'h0001_8000, 32'h0), 1, 1, 0));
    // point before the grid clamps to the first cell
    add_row(row(point_beat(32'h8000_0000, 32'h0001_0000, 32'h8000_0000), 1, 2, 1));
    add_row(row(point_beat(32'h8000, 32'h0001_7fff, 32'h8000), 1, 3, 1));
    // extreme heights at the far corner of the store
    add_row(row(write_beat(16'hffff, 32'h7fff_ffff), 0, 0, 0));
    add_row(row(write_beat(16'hfffe, 32'h8000_0000), 0, 0, 0));
    add_row(row(write_beat(16'hfeff, 32'h7fff_ffff), 0, 0, 0));
    add_row(row(write_beat(16'hfefe, 32'h8000_0000), 0, 0, 0));
    // point past the grid clamps to the last cell with full fractions
    add_row(row(point_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1, 0, 1));
    add_row(row(point_beat(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 1, 1, 0));
    add_row(row(point_beat(32'h7fff_ffff, 32'h0, 32'h8000), 0, 0, 0));
    add_row(row(point_beat(32'h8000, 32'h0, 32'h7fff_ffff), 0, 0, 0));
    add_row(row(point_beat(32'h0001_8000, 32'h0000_c000, 32'h0001_4000), 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed[i]) begin
      b = directed[i].beat;
      if (b.op == OP_POINT && !directed[i].typed) send_point(b.point_x, b.point_y, b.point_z);
      else send_beat(b, directed[i].typed, directed[i].want);
    end
    wait_idle();

    // random phases, each with fresh register settings
    for (int p = 0; p < PHASES; p++) begin
      cfg_write(CFG_ORIGIN_X, pick(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0020_0000) - 32'h0010_0000);
      cfg_write(CFG_ORIGIN_Z, pick(32'h7fff_ffff, 32'h8000_0000, 0, 32'h0020_0000) - 32'h0010_0000);
      cfg_write(CFG_CELL_WIDTH, (p == 1) ? 32'h0 : pick(32'h7fff_ffff, 32'h1, 32'h400, 32'h4_0000));
      cfg_write(CFG_CELL_DEPTH, (p == 2) ? 32'h0 : pick(32'h1, 32'hffff_ffff, 32'h400, 32'h4_0000));
      case (p)
        3: cfg_write(CFG_GRID_WIDTH, 32'd0);
        4: cfg_write(CFG_GRID_WIDTH, 32'd1);
        5: cfg_write(CFG_GRID_WIDTH, 32'd300);
        6: cfg_write(CFG_GRID_WIDTH, 32'h1ff);
        7: cfg_write(CFG_GRID_WIDTH, 32'd2);
        default: cfg_write(CFG_GRID_WIDTH, $urandom_range(2, COLS_MAX));
      endcase
      cfg_write(CFG_GROUND_THRESHOLD, pick(32'h0, 32'hffff_ffff, 32'h100, 32'h4_0000));
      if (p % 3 == 0) cfg_write(CFG_IDX_SPARE, $urandom);
      cfg_valid <= 1'b0;
      @(posedge clk);

      gw = eff_cols();
      cw = (step_x == 0) ? 1 : step_x;
      cd = (step_z == 0) ? 1 : step_z;
      ox = org_x;
      oz = org_z;

      // stream points and stray writes, corners loaded on demand
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0: send_beat(write_beat(16'($urandom), $urandom), 1'b0, '0);
          1: begin
            // noise point anywhere
            send_point($urandom, $urandom, $urandom);
          end
          default: begin
            c = $urandom_range(0, gw);
            rw = $urandom_range(0, 3);
            x = 32'(ox + c * cw + longint'($urandom_range(0, 32'(cw - 1))));
            z = 32'(oz + rw * cd + longint'($urandom_range(0, 32'(cd - 1))));
            if ($urandom_range(0, 15) == 0) x = 32'(ox - 1 - $urandom_range(0, 1000));
            hh = surface_height(x, z);
            tt = thr;
            y = 32'(hh + ($urandom_range(0, 1) ? tt : -tt)
                    + longint'($signed($urandom_range(0, 64))) - 32);
            if ($urandom_range(0, 3) == 0) y = 32'(hh + longint'($urandom_range(0, 255)) - 128);
            send_point(x, y, z);
          end
        endcase
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
